### hw/rtl/rtq_pkg.sv
// ----------------------------------------------------------------------------
// Retransmit timer queue package
// Shared opcodes, status codes and the command record passed front to back.
// ----------------------------------------------------------------------------
package rtq_pkg;

  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_TICK   = 2'd2;

  localparam logic [2:0] ST_ADDED    = 3'd0;
  localparam logic [2:0] ST_FULL     = 3'd1;
  localparam logic [2:0] ST_REMOVED  = 3'd2;
  localparam logic [2:0] ST_NOTFOUND = 3'd3;
  localparam logic [2:0] ST_EXPIRED  = 3'd4;
  localparam logic [2:0] ST_IDLE     = 3'd5;

  localparam int MaxResults = 16;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] handle;
    logic [15:0] timeout;
  } rtq_cmd_t;

endpackage

### hw/rtl/rtq_front.sv
// ----------------------------------------------------------------------------
// Retransmit timer queue front end
// Accepts commands, drops unused opcodes and feeds a two-entry command queue.
// ----------------------------------------------------------------------------
module rtq_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              valid,
  output logic              stall,
  input  logic [1:0]        op,
  input  logic [15:0]       handle,
  input  logic [15:0]       timeout,
  output logic              cmd_valid,
  input  logic              cmd_take,
  output rtq_pkg::rtq_cmd_t cmd
);
  import rtq_pkg::*;

  rtq_cmd_t   q [2];
  logic [1:0] count;
  logic       rd_ptr;
  logic       wr_ptr;
  logic       push;
  logic       pop;
  logic       known;

  assign stall     = (count == 2'd2);
  assign known     = (op == OP_ADD) || (op == OP_REMOVE) || (op == OP_TICK);
  assign push      = valid && !stall && known;
  assign pop       = cmd_take && (count != 2'd0);
  assign cmd_valid = (count != 2'd0);
  assign cmd       = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= 2'd0;
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= '{op: op, handle: handle, timeout: timeout};
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count == 2'd2 |-> !push) else $error("command queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    count == 2'd0 |=> count != 2'd3) else $error("command queue count corrupt");
  a_pop_only_valid: assert property (@(posedge clk) disable iff (rst)
    pop |-> cmd_valid) else $error("pop from empty queue");
`endif

endmodule

### hw/rtl/rtq_back.sv
// ----------------------------------------------------------------------------
// Retransmit timer queue back end
// Sorted timer table walked one slot per cycle; emits results through a
// single output register.
// ----------------------------------------------------------------------------
module rtq_back #(
  parameter int TIMER_SLOTS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  output logic              cmd_take,
  input  rtq_pkg::rtq_cmd_t cmd,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [2:0]        status,
  output logic [15:0]       expired_handle,
  output logic              last
);
  import rtq_pkg::*;

  localparam int IW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam int CW = $clog2(TIMER_SLOTS + 1);
  localparam int KW = $clog2(MaxResults + 1);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_ADD   = 5'b00010,
    S_REM   = 5'b00100,
    S_TICK  = 5'b01000,
    S_SHIFT = 5'b10000
  } state_t;

  state_t         state;
  logic [15:0]    ent_h [TIMER_SLOTS];
  logic [31:0]    ent_e [TIMER_SLOTS];
  logic [CW-1:0]  used;
  logic [31:0]    now;
  logic [CW-1:0]  pos;
  logic [KW-1:0]  emitted;
  rtq_cmd_t       cur;
  logic [31:0]    new_exp;
  logic           out_free;
  logic [IW-1:0]  pidx;
  logic [31:0]    key_new;
  logic [31:0]    key_pos;
  logic [CW-1:0]  shift_end;
  logic           due;

  assign out_free = !out_valid || !out_stall;
  assign cmd_take = (state == S_IDLE) && cmd_valid;
  assign pidx     = pos[IW-1:0];
  assign key_new  = (new_exp - now) ^ 32'h8000_0000;
  assign key_pos  = (ent_e[pidx] - now) ^ 32'h8000_0000;
  assign due      = (used != '0) && ((now - ent_e[0]) < 32'h8000_0000);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      used      <= '0;
      now       <= '0;
      emitted   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            cur     <= cmd;
            new_exp <= now + 32'(cmd.timeout);
            pos     <= '0;
            emitted <= '0;
            unique case (cmd.op)
              OP_ADD:    state <= S_ADD;
              OP_REMOVE: state <= S_REM;
              default: begin
                now   <= now + 32'd1;
                state <= S_TICK;
              end
            endcase
          end
        end
        S_ADD: begin
          if (used == CW'(TIMER_SLOTS)) begin
            if (out_free) begin
              out_valid <= 1'b1; status <= ST_FULL;
              expired_handle <= cur.handle; last <= 1'b1;
              state <= S_IDLE;
            end
          end else if (pos < used && key_pos < key_new) begin
            pos <= pos + 1'b1;
          end else if (out_free) begin
            for (int i = 1; i < TIMER_SLOTS; i++) begin
              if (CW'(i) > pos && CW'(i) <= used) begin
                ent_h[i] <= ent_h[i-1];
                ent_e[i] <= ent_e[i-1];
              end
            end
            ent_h[pidx] <= cur.handle;
            ent_e[pidx] <= new_exp;
            used <= used + 1'b1;
            out_valid <= 1'b1; status <= ST_ADDED;
            expired_handle <= cur.handle; last <= 1'b1;
            state <= S_IDLE;
          end
        end
        S_REM: begin
          if (pos < used && ent_h[pidx] != cur.handle) begin
            pos <= pos + 1'b1;
          end else if (out_free) begin
            out_valid <= 1'b1; expired_handle <= cur.handle; last <= 1'b1;
            if (pos < used) begin
              status <= ST_REMOVED;
              state  <= S_SHIFT;
            end else begin
              status <= ST_NOTFOUND;
              state  <= S_IDLE;
            end
          end
        end
        S_SHIFT: begin
          for (int i = 0; i < TIMER_SLOTS - 1; i++) begin
            if (CW'(i) >= pos && CW'(i + 1) < used) begin
              ent_h[i] <= ent_h[i+1];
              ent_e[i] <= ent_e[i+1];
            end
          end
          used  <= used - 1'b1;
          state <= (cur.op == OP_TICK) ? S_TICK : S_IDLE;
        end
        S_TICK: begin
          if (out_free) begin
            if (due && emitted != KW'(MaxResults)) begin
              out_valid      <= 1'b1;
              status         <= ST_EXPIRED;
              expired_handle <= ent_h[0];
              last           <= !(shift_end > CW'(1) && emitted != KW'(MaxResults - 1)
                                  && ((now - ent_e[1]) < 32'h8000_0000));
              emitted        <= emitted + 1'b1;
              pos            <= '0;
              state          <= S_SHIFT;
            end else begin
              if (emitted == '0) begin
                out_valid <= 1'b1; status <= ST_IDLE;
                expired_handle <= cur.handle; last <= 1'b1;
              end
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign shift_end = used;

`ifndef SYNTH
  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    used <= CW'(TIMER_SLOTS)) else $error("table count beyond capacity");
  a_take_idle: assert property (@(posedge clk) disable iff (rst)
    cmd_take |=> state != S_IDLE) else $error("command taken without work");
  a_emit_bound: assert property (@(posedge clk) disable iff (rst)
    emitted <= KW'(MaxResults)) else $error("too many expiries in one tick");
  a_shift_nonempty: assert property (@(posedge clk) disable iff (rst)
    state == S_SHIFT |-> used != '0) else $error("shift on empty table");
`endif

endmodule

### hw/rtl/retransmit_timer_queue.sv
// ----------------------------------------------------------------------------
// Retransmit timer queue
// Sorted retransmission timer table with add, remove and tick commands.
// ----------------------------------------------------------------------------
// Commands pass through a two-entry queue into a back end that walks the
// sorted table one slot per cycle; a tick emits each expired timer and then
// shifts the table, with at most 16 expiries reported per tick, and the
// unused opcode 3 is dropped silently.
module retransmit_timer_queue #(
  parameter int TIMER_SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  op,
  input  logic [15:0] handle,
  input  logic [15:0] timeout,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [15:0] expired_handle,
  output logic        last
);
  import rtq_pkg::*;

  rtq_cmd_t cmd;
  logic     cmd_valid;
  logic     cmd_take;

  rtq_front u_front (
    .clk(clk), .rst(rst), .valid(in_valid), .stall(in_stall),
    .op(op), .handle(handle), .timeout(timeout),
    .cmd_valid(cmd_valid), .cmd_take(cmd_take), .cmd(cmd)
  );

  rtq_back #(.TIMER_SLOTS(TIMER_SLOTS)) u_back (
    .clk(clk), .rst(rst), .cmd_valid(cmd_valid), .cmd_take(cmd_take), .cmd(cmd),
    .out_valid(out_valid), .out_stall(out_stall), .status(status),
    .expired_handle(expired_handle), .last(last)
  );

endmodule
